/* rtl/hcbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Request mode codes and fixed widths shared by the interfaces and the packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    // Request modes.
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } t_mode;

    // Fixed field widths of the request and result channels.
    localparam int MODE_W   = 2;
    localparam int SYMBOL_W = 8;
    localparam int CODE_W   = 32;
    localparam int CLEN_W   = 6;
    localparam int BYTE_W   = 8;

    // Width of the pending partial byte, one bit short of a full byte.
    localparam int PEND_W   = BYTE_W - 1;

endpackage

/* rtl/hcbp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code bit packer channels
// Valid/ready channels for packer requests and packed output bytes.
// ----------------------------------------------------------------------------
interface hcbp_in_if;
    logic                          valid;
    logic                          ready;
    logic [hcbp_pkg::MODE_W-1:0]   mode;
    logic [hcbp_pkg::SYMBOL_W-1:0] symbol;
    logic [hcbp_pkg::CODE_W-1:0]   code_word;
    logic [hcbp_pkg::CLEN_W-1:0]   code_length;

    modport source (output valid, mode, symbol, code_word, code_length, input ready);
    modport sink   (input valid, mode, symbol, code_word, code_length, output ready);
endinterface

interface hcbp_out_if;
    logic                        valid;
    logic                        ready;
    logic [hcbp_pkg::BYTE_W-1:0] out_byte;
    logic                        run_end;
    logic                        stream_end;
    logic                        unknown_symbol;

    modport source (output valid, out_byte, run_end, stream_end, unknown_symbol,
                    input ready);
    modport sink   (input valid, out_byte, run_end, stream_end, unknown_symbol,
                     output ready);
endinterface

/* rtl/huffman_code_bit_packer.sv */
`timescale 1ns / 1ps
// Rate: a request is taken in every cycle while the byte emitter can keep up.
// Load requests, flushes with nothing pending and encodes that complete no
// byte produce no result and never wait on the output. An encode that
// completes N bytes (N up to (MAX_CODE_BITS + 7) / 8) and a flush or unknown
// symbol (one byte) occupy the output register until their bytes are taken,
// one byte per cycle while the output is ready; the request register holds
// the next request meanwhile. The code table read goes into the request
// register, and the packed bytes then go into the output register.
// The valid bits of the code table are flip-flops cleared by reset, so no
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Code table plus MSB-first bit packer: loads table entries, packs encoded
// symbols into bytes and pads the final partial byte on flush.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT  = 256,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hcbp_in_if.sink           i_req,
    hcbp_out_if.source        o_res
);

    localparam int IDX_W     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_W     = $clog2(MAX_CODE_BITS + 1);
    localparam int ACC_W     = MAX_CODE_BITS + hcbp_pkg::BYTE_W;
    localparam int CNT_W     = $clog2(ACC_W + 1);
    localparam int MAX_BYTES = (MAX_CODE_BITS + hcbp_pkg::PEND_W) / hcbp_pkg::BYTE_W;
    localparam int NB_W      = $clog2(MAX_BYTES + 1);
    localparam int ENTRY_W   = LEN_W + MAX_CODE_BITS;
    localparam int BW        = hcbp_pkg::BYTE_W;
    localparam int PW        = hcbp_pkg::PEND_W;

    // Code table memory and its valid bits.
    logic [ENTRY_W-1:0]      mem_table [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_entry_vld;

    // Request register, holding the table read data.
    logic                     r_a_vld;
    logic [1:0]               r_a_mode;
    logic                     r_a_hit;
    logic [MAX_CODE_BITS-1:0] r_a_code;
    logic [LEN_W-1:0]         r_a_len;

    // Pending partial byte.
    logic [PW-1:0]            r_pend_bits;
    logic [2:0]               r_pend_cnt;

    // Byte emitter, which is also the output register.
    logic [ACC_W-1:0]         r_em_data;
    logic [NB_W-1:0]          r_em_left;
    logic                     r_em_stream;
    logic                     r_em_unknown;

    logic                     in_acc;
    logic                     in_range;
    logic [IDX_W-1:0]         sym_idx;
    logic [LEN_W-1:0]         len_sat;
    logic                     is_load;
    logic                     em_free;
    logic                     a_fire;
    logic                     out_acc;

    logic [ACC_W-1:0]         c_code;
    logic [ACC_W-1:0]         c_acc;
    logic [CNT_W-1:0]         c_cnt;
    logic [ACC_W-1:0]         c_al;
    logic [PW-1:0]            c_pend;
    logic [BW-1:0]            c_flush_byte;

    logic                     e_load;
    logic [ACC_W-1:0]         e_data;
    logic [NB_W-1:0]          e_left;
    logic                     e_stream;
    logic                     e_unknown;
    logic                     p_upd;
    logic [PW-1:0]            p_bits;
    logic [2:0]               p_cnt;

    // Request decode and table addressing.
    assign sym_idx  = i_req.symbol[IDX_W-1:0];
    assign in_range = ({1'b0, i_req.symbol} < (hcbp_pkg::SYMBOL_W + 1)'(SYMBOL_COUNT));
    assign is_load  = (i_req.mode == hcbp_pkg::MODE_LOAD);
    assign len_sat  = (i_req.code_length > hcbp_pkg::CLEN_W'(MAX_CODE_BITS))
                    ? LEN_W'(MAX_CODE_BITS) : LEN_W'(i_req.code_length);

    // Handshakes.
    assign out_acc     = o_res.valid && o_res.ready;
    assign em_free     = (r_em_left == '0) || ((r_em_left == NB_W'(1)) && o_res.ready);
    assign a_fire      = r_a_vld && (!e_load || em_free);
    assign i_req.ready = !r_a_vld || a_fire;
    assign in_acc      = i_req.valid && i_req.ready;

    // Append the code to the pending bits and left-align the result.
    always_comb begin
        c_code       = ACC_W'(r_a_code) & ~({ACC_W{1'b1}} << r_a_len);
        c_acc        = (ACC_W'(r_pend_bits) << r_a_len) | c_code;
        c_cnt        = CNT_W'(r_pend_cnt) + CNT_W'(r_a_len);
        c_al         = c_acc << (CNT_W'(ACC_W) - c_cnt);
        c_pend       = c_acc[PW-1:0] & ~({PW{1'b1}} << c_cnt[2:0]);
        c_flush_byte = BW'({1'b0, r_pend_bits} << (4'd8 - {1'b0, r_pend_cnt}));
    end

    // Decide what the current request hands to the emitter and to the pending bits.
    always_comb begin
        e_load    = 1'b0;
        e_data    = '0;
        e_left    = '0;
        e_stream  = 1'b0;
        e_unknown = 1'b0;
        p_upd     = 1'b0;
        p_bits    = r_pend_bits;
        p_cnt     = r_pend_cnt;
        unique case (r_a_mode)
            hcbp_pkg::MODE_ENCODE: begin
                if (!r_a_hit) begin
                    e_load    = 1'b1;
                    e_left    = NB_W'(1);
                    e_unknown = 1'b1;
                end else begin
                    e_load = (c_cnt >= CNT_W'(BW));
                    e_data = c_al;
                    e_left = NB_W'(c_cnt >> 3);
                    p_upd  = 1'b1;
                    p_bits = c_pend;
                    p_cnt  = c_cnt[2:0];
                end
            end
            hcbp_pkg::MODE_FLUSH: begin
                if (r_pend_cnt != 3'd0) begin
                    e_load   = 1'b1;
                    e_data   = {c_flush_byte, {(ACC_W - BW){1'b0}}};
                    e_left   = NB_W'(1);
                    e_stream = 1'b1;
                    p_upd    = 1'b1;
                    p_bits   = '0;
                    p_cnt    = 3'd0;
                end
            end
            default: begin
                e_load = 1'b0;
            end
        endcase
    end

    // Control state: request register valid, table valid bits, pending bits, emitter count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_entry_vld <= '0;
            r_pend_bits <= '0;
            r_pend_cnt  <= 3'd0;
            r_em_left   <= '0;
        end else begin
            if (in_acc) begin
                r_a_vld <= 1'b1;
            end else if (a_fire) begin
                r_a_vld <= 1'b0;
            end
            if (in_acc && is_load && in_range) begin
                r_entry_vld[sym_idx] <= 1'b1;
            end
            if (a_fire && p_upd) begin
                r_pend_bits <= p_bits;
                r_pend_cnt  <= p_cnt;
            end
            if (a_fire && e_load) begin
                r_em_left <= e_left;
            end else if (out_acc) begin
                r_em_left <= r_em_left - NB_W'(1);
            end
        end
    end

    // Request payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_mode <= i_req.mode;
            r_a_hit  <= in_range && r_entry_vld[sym_idx];
        end
    end

    // Code table: written by loads, read on every accepted request.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            {r_a_len, r_a_code} <= mem_table[sym_idx];
            if (is_load && in_range) begin
                mem_table[sym_idx] <= {len_sat, i_req.code_word[MAX_CODE_BITS-1:0]};
            end
        end
    end

    // Emitter payload: load a packed word, then shift one byte out per result.
    always_ff @(posedge i_clk) begin
        if (a_fire && e_load) begin
            r_em_data    <= e_data;
            r_em_stream  <= e_stream;
            r_em_unknown <= e_unknown;
        end else if (out_acc) begin
            r_em_data <= r_em_data << BW;
        end
    end

    // Result channel.
    assign o_res.valid          = (r_em_left != '0);
    assign o_res.out_byte       = r_em_data[ACC_W-1 -: BW];
    assign o_res.run_end        = (r_em_left == NB_W'(1));
    assign o_res.stream_end     = r_em_stream;
    assign o_res.unknown_symbol = r_em_unknown;

    // The emitter never holds more bytes than one code can complete.
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_em_left <= NB_W'(MAX_BYTES))
        else $error("emitter byte count out of range");

    // An unknown symbol gives a single zero byte.
    a_unknown_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.unknown_symbol |-> (o_res.out_byte == '0) && o_res.run_end)
        else $error("unknown symbol result is not a single zero byte");

    // The flush byte is always the last one of its request.
    a_stream_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.stream_end |-> o_res.run_end && !o_res.unknown_symbol)
        else $error("stream end byte is not the last result");

    // Bytes of one request follow without a gap.
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !o_res.run_end |=> o_res.valid)
        else $error("result run broken before its last byte");

    // Nothing is presented right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");

endmodule
